// ----- src/lif_pkg.sv -----
// shared types and constants for the lms imitation filter
// no dependencies; used by every module of the block
package lif_pkg;

  localparam int SMP_W   = 24;
  localparam int COEF_W  = 32;
  localparam int MU_W    = 16;
  localparam int LIM_W   = 23;
  localparam int CFG_W   = 23;
  localparam int MUE_W   = MU_W + 1 + SMP_W;
  localparam int PROD_W  = SMP_W + COEF_W;
  localparam int DELTA_W = 28;
  // ring slots held by the shared arithmetic pipeline
  localparam int PIPE_L  = 4;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT = 1'b1;

  localparam logic [MU_W-1:0]  STEP_RATE_RST   = 16'd655;
  localparam logic [LIM_W-1:0] ERROR_LIMIT_RST = 23'd4194;

  typedef struct packed {
    logic signed [SMP_W-1:0] ref_unfiltered;
    logic signed [SMP_W-1:0] ref_filtered;
    logic signed [SMP_W-1:0] signal_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] filtered_out;
    logic signed [SMP_W-1:0] est_error;
  } out_item_t;

  // one tap of state: reference sample, signal sample, coefficient
  typedef struct packed {
    logic signed [SMP_W-1:0]  ref_smp;
    logic signed [SMP_W-1:0]  sig_smp;
    logic signed [COEF_W-1:0] coef;
  } tap_t;

  typedef struct packed {
    logic rotate;
    logic push;
  } cell_ctrl_t;

  typedef struct packed {
    logic advance;
    logic upd_en;
    logic sel_sig;
    logic acc_clr;
    logic acc_en;
  } mac_ctrl_t;

endpackage

// ----- src/lif_cell.sv -----
// one cell of the tap ring: holds one tap and takes its neighbor's
// depends on lif_pkg
module lif_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  lif_pkg::cell_ctrl_t ctrl,
  input  lif_pkg::tap_t      nbr,
  output lif_pkg::tap_t      tap
);
  import lif_pkg::*;

  tap_t tap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
    end else if (ctrl.rotate) begin
      tap_r <= nbr;
    end else if (ctrl.push) begin
      // samples slide toward the head, coefficient stays in place
      tap_r.ref_smp <= nbr.ref_smp;
      tap_r.sig_smp <= nbr.sig_smp;
    end
  end

  assign tap = tap_r;

endmodule

// ----- src/lif_mac.sv -----
// shared arithmetic pipeline closing the tap ring: coefficient update
// and multiply-accumulate for both dot products; depends on lif_pkg
module lif_mac #(
  parameter int ACC_W = 61
) (
  input  logic                               clk,
  input  lif_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [lif_pkg::MUE_W-1:0]   mu_e,
  input  lif_pkg::tap_t                      head,
  output lif_pkg::tap_t                      tail,
  output logic signed [ACC_W-1:0]            acc
);
  import lif_pkg::*;

  localparam int HI_W  = MUE_W - 20;
  localparam int PP_W  = HI_W + SMP_W;
  localparam int SUM_W = PP_W + 21;

  localparam logic signed [SUM_W-1:0]    UPD_HALF = SUM_W'(1) <<< 37;
  localparam logic signed [COEF_W:0]     COEF_HI  = (COEF_W+1)'(33'sh0_7FFF_FFFF);
  localparam logic signed [COEF_W:0]     COEF_LO  = (COEF_W+1)'(33'sh1_8000_0000);

  tap_t s1_r, s2_r, s3_r, s4_r;
  tap_t s4_nxt;
  logic signed [PP_W-1:0]    ph_r, pl_r;
  logic signed [DELTA_W-1:0] delta_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;

  logic signed [HI_W-1:0]    mu_hi;
  logic signed [HI_W-1:0]    mu_lo;
  logic signed [SUM_W-1:0]   upd_sum;
  logic signed [COEF_W:0]    coef_sum;
  logic signed [COEF_W-1:0]  coef_new;
  logic signed [SMP_W-1:0]   mul_a;

  // mu*e split in two halves so each product stays narrow
  assign mu_hi = mu_e[MUE_W-1:20];
  assign mu_lo = $signed({1'b0, mu_e[19:0]});

  assign upd_sum = $signed({ph_r, 20'b0}) + SUM_W'(pl_r) + UPD_HALF;

  assign coef_sum = (COEF_W+1)'(s3_r.coef) + (COEF_W+1)'(delta_r);

  always_comb begin
    if (coef_sum > COEF_HI) begin
      coef_new = COEF_W'(COEF_HI);
    end else if (coef_sum < COEF_LO) begin
      coef_new = COEF_W'(COEF_LO);
    end else begin
      coef_new = coef_sum[COEF_W-1:0];
    end
  end

  always_comb begin
    s4_nxt = s3_r;
    if (ctrl.upd_en) begin
      s4_nxt.coef = coef_new;
    end
  end

  assign mul_a = ctrl.sel_sig ? s4_r.sig_smp : s4_r.ref_smp;

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      s1_r    <= head;
      s2_r    <= s1_r;
      ph_r    <= mu_hi * s1_r.ref_smp;
      pl_r    <= mu_lo * s1_r.ref_smp;
      s3_r    <= s2_r;
      delta_r <= upd_sum[SUM_W-1:38];
      s4_r    <= s4_nxt;
    end
    prod_r <= mul_a * s4_r.coef;
    if (ctrl.acc_clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign tail = s4_r;
  assign acc  = acc_r;

endmodule

// ----- src/lms_imitation_filter_top.sv -----
// LMS adaptive FIR that learns to imitate a filter. The taps sit in a ring of
// TAPS cells closed through a four-slot arithmetic pipeline with one shared
// multiply-accumulate; each request rotates the ring fully twice, once for the
// reference estimate and once for the coefficient update together with the
// signal dot product, and the block takes no new request until the result has
// been loaded into the output register. A finished result waits in the
// output register while the next request is taken.
// top level; depends on lif_pkg, lif_cell, lif_mac
module lms_imitation_filter_top #(
  parameter int TAPS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lif_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lif_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [lif_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lif_pkg::CFG_W-1:0]       cfg_wdata
);
  import lif_pkg::*;

  localparam int ACC_W = PROD_W + $clog2(TAPS) + 1;
  localparam int EST_W = ACC_W - 24;
  localparam int ERR_W = EST_W + 1;
  localparam int RING  = TAPS + PIPE_L;
  localparam int CNT_W = $clog2(RING);

  localparam logic signed [ACC_W-1:0] DOT_HALF = ACC_W'(1) <<< 23;
  localparam logic signed [ERR_W-1:0] ERR_HI   = (1 <<< 23) - 1;
  localparam logic signed [ERR_W-1:0] ERR_LO   = -(1 <<< 23);
  localparam logic signed [EST_W-1:0] EST_HI   = (1 <<< 23) - 1;
  localparam logic signed [EST_W-1:0] EST_LO   = -(1 <<< 23);

  typedef enum logic [3:0] {
    S_IDLE, S_PASS_A, S_DRAIN_A, S_EST, S_ERR, S_CLIP, S_MUE,
    S_PASS_B, S_DRAIN_B, S_RND, S_DONE
  } state_t;

  state_t                    state_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      prod_vld_r;
  logic                      out_valid_r;
  out_item_t                 out_data_r;
  logic [MU_W-1:0]           step_rate_r;
  logic [LIM_W-1:0]          error_limit_r;
  logic signed [SMP_W-1:0]   target_r;
  logic signed [EST_W-1:0]   est_r;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [SMP_W-1:0]   clip_r;
  logic signed [SMP_W-1:0]   err_sat_r;
  logic signed [MUE_W-1:0]   mu_e_r;

  tap_t                      cell_tap [TAPS];
  tap_t                      ring_tail;
  tap_t                      tail_in;
  cell_ctrl_t                cell_ctrl;
  mac_ctrl_t                 mac_ctrl;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [ERR_W-1:0]   lim_ext;
  logic signed [SMP_W-1:0]   est_sat;
  logic                      accept;
  logic                      passing;
  logic                      out_free;
  logic                      load_out;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign passing  = (state_r == S_PASS_A) || (state_r == S_PASS_B);
  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (state_r == S_DONE) && out_free;

  assign cell_ctrl.rotate = passing;
  assign cell_ctrl.push   = accept;

  assign mac_ctrl.advance = passing;
  assign mac_ctrl.upd_en  = (state_r == S_PASS_B);
  assign mac_ctrl.sel_sig = (state_r == S_PASS_B);
  assign mac_ctrl.acc_clr = accept || (state_r == S_MUE);
  assign mac_ctrl.acc_en  = prod_vld_r;

  // tail cell takes the new samples on a request, the pipeline output on rotation
  always_comb begin
    if (accept) begin
      tail_in.ref_smp = in_data.ref_unfiltered;
      tail_in.sig_smp = in_data.signal_in;
      tail_in.coef    = cell_tap[TAPS-1].coef;
    end else begin
      tail_in = ring_tail;
    end
  end

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    if (i == TAPS - 1) begin : g_tail
      lif_cell u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (cell_ctrl),
        .nbr  (tail_in),
        .tap  (cell_tap[i])
      );
    end else begin : g_body
      lif_cell u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (cell_ctrl),
        .nbr  (cell_tap[i+1]),
        .tap  (cell_tap[i])
      );
    end
  end

  lif_mac #(
    .ACC_W(ACC_W)
  ) u_mac (
    .clk (clk),
    .ctrl(mac_ctrl),
    .mu_e(mu_e_r),
    .head(cell_tap[0]),
    .tail(ring_tail),
    .acc (acc)
  );

  assign acc_rnd = acc + DOT_HALF;
  assign lim_ext = $signed({{(ERR_W-LIM_W){1'b0}}, error_limit_r});

  always_comb begin
    if (est_r > EST_HI) begin
      est_sat = SMP_W'(EST_HI);
    end else if (est_r < EST_LO) begin
      est_sat = SMP_W'(EST_LO);
    end else begin
      est_sat = est_r[SMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      prod_vld_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      step_rate_r   <= STEP_RATE_RST;
      error_limit_r <= ERROR_LIMIT_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_RATE:   step_rate_r   <= cfg_wdata[MU_W-1:0];
          CFG_ERROR_LIMIT: error_limit_r <= cfg_wdata[LIM_W-1:0];
          default: ;
        endcase
      end

      // products leave the pipeline once the first tap has reached its end
      prod_vld_r <= passing && (cnt_r >= CNT_W'(PIPE_L));

      if (load_out) begin
        out_data_r.filtered_out <= est_sat;
        out_data_r.est_error    <= err_sat_r;
        out_valid_r             <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            target_r <= in_data.ref_filtered;
            cnt_r    <= '0;
            state_r  <= S_PASS_A;
          end
        end
        S_PASS_A, S_PASS_B: begin
          if (cnt_r == CNT_W'(RING - 1)) begin
            cnt_r   <= '0;
            state_r <= (state_r == S_PASS_A) ? S_DRAIN_A : S_DRAIN_B;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DRAIN_A: begin
          state_r <= S_EST;
        end
        S_EST: begin
          est_r   <= acc_rnd[ACC_W-1:24];
          state_r <= S_ERR;
        end
        S_ERR: begin
          err_r   <= ERR_W'(target_r) - ERR_W'(est_r);
          state_r <= S_CLIP;
        end
        S_CLIP: begin
          if (err_r > lim_ext) begin
            clip_r <= SMP_W'(lim_ext);
          end else if (err_r < -lim_ext) begin
            clip_r <= SMP_W'(-lim_ext);
          end else begin
            clip_r <= err_r[SMP_W-1:0];
          end
          if (err_r > ERR_HI) begin
            err_sat_r <= SMP_W'(ERR_HI);
          end else if (err_r < ERR_LO) begin
            err_sat_r <= SMP_W'(ERR_LO);
          end else begin
            err_sat_r <= err_r[SMP_W-1:0];
          end
          state_r <= S_MUE;
        end
        S_MUE: begin
          mu_e_r  <= $signed({1'b0, step_rate_r}) * clip_r;
          state_r <= S_PASS_B;
        end
        S_DRAIN_B: begin
          state_r <= S_RND;
        end
        S_RND: begin
          est_r   <= acc_rnd[ACC_W-1:24];
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/lif_checker.sv -----
// port-level checks for the lms imitation filter, bound to the top level
// depends on lif_pkg and lms_imitation_filter_top
module lif_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input lif_pkg::out_item_t     out_data
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request at a time: busy right after a request
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  // a result never appears the cycle after a request
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too early");

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind lms_imitation_filter_top lif_checker u_lif_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
